/* rtl/core/int_divider_signed_unsigned_top_defines.svh */
// ---------------------------------------------------------------------------
// int_divider_signed_unsigned_top_defines
// assertion macros shared by the divider rtl, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef INT_DIVIDER_SIGNED_UNSIGNED_TOP_DEFINES_SVH
`define INT_DIVIDER_SIGNED_UNSIGNED_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define IDSU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define IDSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IDSU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define IDSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/core/idsu_pkg.sv */
// ---------------------------------------------------------------------------
// idsu_pkg
// widths, operation codes and control types of the integer divider
// ---------------------------------------------------------------------------
package idsu_pkg;

  localparam int DATA_W  = 64;
  localparam int HALF_W  = 32;
  localparam int KIND_W  = 2;
  localparam int CNT_W   = $clog2(DATA_W);
  localparam int OP_W    = 3;

  localparam int KIND_SIGN_BIT = 0;
  localparam int KIND_WIDE_BIT = 1;

  localparam logic [OP_W-1:0] OP_HOLD = 3'd0;
  localparam logic [OP_W-1:0] OP_CLR  = 3'd1;
  localparam logic [OP_W-1:0] OP_NEGN = 3'd2;
  localparam logic [OP_W-1:0] OP_NEGD = 3'd3;
  localparam logic [OP_W-1:0] OP_STEP = 3'd4;
  localparam logic [OP_W-1:0] OP_NEGQ = 3'd5;
  localparam logic [OP_W-1:0] OP_NEGR = 3'd6;

  typedef struct packed {
    logic            load;
    logic [OP_W-1:0] op;
  } idsu_ctrl_t;

  typedef struct packed {
    logic den_zero;
    logic n_neg;
    logic d_neg;
  } idsu_stat_t;

  function automatic logic [DATA_W-1:0] width_mask(input logic wide);
    width_mask = wide ? {DATA_W{1'b1}} : {{(DATA_W-HALF_W){1'b0}}, {HALF_W{1'b1}}};
  endfunction

  function automatic logic sign_of(input logic [DATA_W-1:0] v, input logic wide);
    sign_of = wide ? v[DATA_W-1] : v[HALF_W-1];
  endfunction

endpackage

/* rtl/core/idsu_req_if.sv */
// ---------------------------------------------------------------------------
// idsu_req_if
// request channel of the integer divider: kind, dividend, divisor
// ---------------------------------------------------------------------------
interface idsu_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] dividend;
  logic [63:0] divisor;

  modport source (output valid, output kind, output dividend, output divisor, input ready);
  modport sink   (input valid, input kind, input dividend, input divisor, output ready);
endinterface

/* rtl/core/idsu_rsp_if.sv */
// ---------------------------------------------------------------------------
// idsu_rsp_if
// result channel of the integer divider: quotient, remainder, zero flag
// ---------------------------------------------------------------------------
interface idsu_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] quotient;
  logic [63:0] remainder;
  logic        divide_by_zero;

  modport source (output valid, output quotient, output remainder,
                  output divide_by_zero, input ready);
  modport sink   (input valid, input quotient, input remainder,
                  input divide_by_zero, output ready);
endinterface

/* rtl/core/idsu_core.sv */
// ---------------------------------------------------------------------------
// idsu_core
// divider datapath: operand registers around one shared 65-bit subtractor
// used for negation, restoring steps and sign fix-up
// ---------------------------------------------------------------------------
module idsu_core (
  input  logic                              clk,
  input  idsu_pkg::idsu_ctrl_t              ctrl,
  input  logic [idsu_pkg::KIND_W-1:0]       kind,
  input  logic [idsu_pkg::DATA_W-1:0]       dividend,
  input  logic [idsu_pkg::DATA_W-1:0]       divisor,
  output idsu_pkg::idsu_stat_t              stat,
  output logic [idsu_pkg::DATA_W-1:0]       quotient,
  output logic [idsu_pkg::DATA_W-1:0]       remainder,
  output logic                              divide_by_zero
);
  import idsu_pkg::*;

  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] den_r, den_nxt;
  logic              wide_r, wide_nxt;
  logic              n_neg_r, n_neg_nxt;
  logic              d_neg_r, d_neg_nxt;
  logic              dz_r, dz_nxt;

  logic [DATA_W:0]   sub_a, sub_b, diff;
  logic [DATA_W-1:0] mask, ld_mask, ld_n, ld_d;
  logic              ld_wide, ld_sgn;

  assign mask    = width_mask(wide_r);
  assign ld_wide = kind[KIND_WIDE_BIT];
  assign ld_sgn  = kind[KIND_SIGN_BIT];
  assign ld_mask = width_mask(ld_wide);
  assign ld_n    = dividend & ld_mask;
  assign ld_d    = divisor & ld_mask;

  // shared subtractor
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (ctrl.op)
      OP_NEGN: sub_b = {1'b0, quo_r};
      OP_NEGD: sub_b = {1'b0, den_r};
      OP_NEGQ: sub_b = {1'b0, quo_r};
      OP_NEGR: sub_b = {1'b0, rem_r};
      OP_STEP: begin
        sub_a = {rem_r, quo_r[DATA_W-1]};
        sub_b = {1'b0, den_r};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
    diff = sub_a - sub_b;
  end

  always_comb begin
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    wide_nxt  = wide_r;
    n_neg_nxt = n_neg_r;
    d_neg_nxt = d_neg_r;
    dz_nxt    = dz_r;
    if (ctrl.load) begin
      quo_nxt   = ld_n;
      rem_nxt   = '0;
      den_nxt   = ld_d;
      wide_nxt  = ld_wide;
      n_neg_nxt = ld_sgn & sign_of(ld_n, ld_wide);
      d_neg_nxt = ld_sgn & sign_of(ld_d, ld_wide);
      dz_nxt    = (ld_d == '0);
    end else begin
      case (ctrl.op)
        OP_CLR: begin
          quo_nxt = '0;
          rem_nxt = '0;
        end
        OP_NEGN: quo_nxt = diff[DATA_W-1:0] & mask;
        OP_NEGD: den_nxt = diff[DATA_W-1:0] & mask;
        OP_NEGQ: quo_nxt = diff[DATA_W-1:0] & mask;
        OP_NEGR: rem_nxt = diff[DATA_W-1:0] & mask;
        OP_STEP: begin
          // no borrow means the shifted remainder reached the divisor
          if (!diff[DATA_W]) begin
            rem_nxt = diff[DATA_W-1:0];
          end else begin
            rem_nxt = sub_a[DATA_W-1:0];
          end
          quo_nxt = {quo_r[DATA_W-2:0], ~diff[DATA_W]};
        end
        default: begin
          quo_nxt = quo_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    wide_r  <= wide_nxt;
    n_neg_r <= n_neg_nxt;
    d_neg_r <= d_neg_nxt;
    dz_r    <= dz_nxt;
  end

  assign stat.den_zero  = dz_r;
  assign stat.n_neg     = n_neg_r;
  assign stat.d_neg     = d_neg_r;
  assign quotient       = quo_r;
  assign remainder      = rem_r;
  assign divide_by_zero = dz_r;

endmodule

/* rtl/core/int_divider_signed_unsigned_top.sv */
// ---------------------------------------------------------------------------
// int_divider_signed_unsigned_top
// signed and unsigned 32/64-bit integer divider, one request at a time
// ---------------------------------------------------------------------------
// Takes one request beat, then holds in_ch.ready low until the result beat
// has been taken. A restoring shift-and-subtract loop runs 64 steps on one
// shared 65-bit subtractor, for every kind; that subtractor also negates the
// signed operands before the loop and the quotient and remainder after it.
// After the request beat the states run S_NEGN, S_NEGD, S_DIV, S_FIXQ,
// S_FIXR and S_DONE, with S_NEGN going straight to S_DONE on a zero
// divisor. The next request can be taken in the cycle after the result
// beat, so output stalls delay it. Signed kinds truncate toward zero with
// the remainder following the dividend's sign; a zero divisor returns zero
// results with divide_by_zero set.
`include "int_divider_signed_unsigned_top_defines.svh"

module int_divider_signed_unsigned_top (
  input  logic        clk,
  input  logic        rst_n,
  idsu_req_if.sink    in_ch,
  idsu_rsp_if.source  out_ch
);
  import idsu_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NEGN = 3'd1;
  localparam logic [2:0] S_NEGD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIXQ = 3'd4;
  localparam logic [2:0] S_FIXR = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  idsu_ctrl_t       ctrl;
  idsu_stat_t       stat;
  logic             in_beat, out_beat;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_DONE);
  assign in_beat      = in_ch.valid & in_ch.ready;
  assign out_beat     = out_ch.valid & out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctrl.load = 1'b0;
    ctrl.op   = OP_HOLD;
    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          ctrl.load = 1'b1;
          state_nxt = S_NEGN;
        end
      end
      S_NEGN: begin
        if (stat.den_zero) begin
          ctrl.op   = OP_CLR;
          state_nxt = S_DONE;
        end else begin
          ctrl.op   = stat.n_neg ? OP_NEGN : OP_HOLD;
          state_nxt = S_NEGD;
        end
      end
      S_NEGD: begin
        ctrl.op   = stat.d_neg ? OP_NEGD : OP_HOLD;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        ctrl.op = OP_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_W-1)) begin
          state_nxt = S_FIXQ;
        end
      end
      S_FIXQ: begin
        ctrl.op   = (stat.n_neg ^ stat.d_neg) ? OP_NEGQ : OP_HOLD;
        state_nxt = S_FIXR;
      end
      S_FIXR: begin
        ctrl.op   = stat.n_neg ? OP_NEGR : OP_HOLD;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_beat) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  idsu_core u_core (
    .clk            (clk),
    .ctrl           (ctrl),
    .kind           (in_ch.kind),
    .dividend       (in_ch.dividend),
    .divisor        (in_ch.divisor),
    .stat           (stat),
    .quotient       (out_ch.quotient),
    .remainder      (out_ch.remainder),
    .divide_by_zero (out_ch.divide_by_zero)
  );

  // checks
  `IDSU_ASSERT_SAME(a_no_overlap, clk, rst_n, in_ch.ready, !out_ch.valid, "ready while result pending")
  `IDSU_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_beat, !in_ch.ready, "request taken while busy")
  `IDSU_ASSERT_SAME(a_zero_div, clk, rst_n, out_ch.valid && out_ch.divide_by_zero, out_ch.quotient == '0 && out_ch.remainder == '0, "zero divisor gave nonzero result")
  `IDSU_ASSERT_NEXT(a_loop_end, clk, rst_n, state_r == S_DIV && cnt_r == CNT_W'(DATA_W-1), state_r == S_FIXQ, "division loop did not end after 64 steps")

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the signed/unsigned 32/64-bit integer divider
// ---------------------------------------------------------------------------
// A short table of directed requests covers zero divisors, the most negative
// value over minus one, ignored high bits in the 32-bit kinds and the sign
// rules. Random requests follow. Every result beat is checked field by field
// against a typed table result or a local model of the division. Both sides
// idle at random, the result side holds off once for a long stretch and the
// request side drains the divider once before going on.
module testbench;
  import idsu_pkg::*;

  localparam logic [KIND_W-1:0] KIND_U32 = 2'd0;
  localparam logic [KIND_W-1:0] KIND_S32 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_U64 = 2'd2;
  localparam logic [KIND_W-1:0] KIND_S64 = 2'd3;

  localparam int RANDOM_ITEMS   = 680;
  localparam int HOLD_AT        = 230;
  localparam int DRAIN_AT       = 470;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 80;

  typedef struct packed {
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
    logic              divide_by_zero;
  } div_result_t;

  typedef struct packed {
    logic              typed;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
    div_result_t       result;
  } div_row_t;

  localparam div_result_t UNTYPED = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  idsu_req_if div_req ();
  idsu_rsp_if div_rsp ();

  int_divider_signed_unsigned_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (div_req),
    .out_ch (div_rsp)
  );

  always #1 clk = ~clk;

  div_result_t expected_results[$];
  div_row_t    directed_rows[$];
  div_result_t head_result;
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  logic        calm = 1'b0;
  logic        hold_off_req = 1'b0;

  function automatic div_result_t divide_predict(input logic [KIND_W-1:0] kind,
                                                 input logic [DATA_W-1:0] dividend,
                                                 input logic [DATA_W-1:0] divisor);
    div_result_t       res;
    logic              wide;
    logic              sgn;
    logic              n_neg;
    logic              d_neg;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] msb;
    logic [DATA_W-1:0] n;
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] n_mag;
    logic [DATA_W-1:0] d_mag;
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] r;
    res   = '0;
    wide  = kind[KIND_WIDE_BIT];
    sgn   = kind[KIND_SIGN_BIT];
    mask  = wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
    msb   = wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
    n     = dividend & mask;
    d     = divisor & mask;
    if (d == '0) begin
      res.divide_by_zero = 1'b1;
    end else begin
      n_neg = sgn && ((n & msb) != '0);
      d_neg = sgn && ((d & msb) != '0);
      n_mag = n_neg ? ((-n) & mask) : n;
      d_mag = d_neg ? ((-d) & mask) : d;
      q = n_mag / d_mag;
      r = n_mag % d_mag;
      if (n_neg != d_neg) q = -q;
      if (n_neg) r = -r;
      res.quotient  = q & mask;
      res.remainder = r & mask;
    end
    return res;
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [DATA_W-1:0] rand_operand();
    logic [DATA_W-1:0] raw;
    logic [DATA_W-1:0] value;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: value = raw >> $urandom_range(1, 63);
      1: value = {raw[63:32], 24'h0, raw[7:0]};
      2: value = ~(raw >> $urandom_range(32, 63));
      3: begin
        case ($urandom_range(0, 5))
          0: value = 64'h8000_0000_0000_0000;
          1: value = 64'hFFFF_FFFF_FFFF_FFFF;
          2: value = {raw[63:32], 32'h8000_0000};
          3: value = {raw[63:32], 32'hFFFF_FFFF};
          4: value = 64'h7FFF_FFFF_FFFF_FFFF;
          default: value = {raw[63:32], 32'h0000_0001};
        endcase
      end
      default: value = raw;
    endcase
    return value;
  endfunction

  task automatic offer_request(input logic [KIND_W-1:0] kind,
                               input logic [DATA_W-1:0] dividend,
                               input logic [DATA_W-1:0] divisor,
                               input div_result_t       expected);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      div_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    div_req.valid    <= 1'b1;
    div_req.kind     <= kind;
    div_req.dividend <= dividend;
    div_req.divisor  <= divisor;
    do @(posedge clk); while (!div_req.ready);
    expected_results.push_back(expected);
  endtask

  task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // request side
  initial begin
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
    div_row_t          row;
    div_req.valid    <= 1'b0;
    div_req.kind     <= KIND_U32;
    div_req.dividend <= '0;
    div_req.divisor  <= '0;

    directed_rows.push_back('{1'b1, KIND_U32, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
                              '{64'h0, 64'h0, 1'b1}});
    directed_rows.push_back('{1'b1, KIND_S32, 64'h0000_0000_8000_0000, 64'h0,
                              '{64'h0, 64'h0, 1'b1}});
    directed_rows.push_back('{1'b1, KIND_U64, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
                              '{64'h0, 64'h0, 1'b1}});
    directed_rows.push_back('{1'b1, KIND_S64, 64'h8000_0000_0000_0000, 64'h0,
                              '{64'h0, 64'h0, 1'b1}});
    directed_rows.push_back('{1'b1, KIND_S32, 64'h0000_0000_8000_0000, 64'h0000_0000_FFFF_FFFF,
                              '{64'h0000_0000_8000_0000, 64'h0, 1'b0}});
    directed_rows.push_back('{1'b1, KIND_S64, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                              '{64'h8000_0000_0000_0000, 64'h0, 1'b0}});
    directed_rows.push_back('{1'b1, KIND_U32, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1,
                              '{64'h0000_0000_FFFF_FFFF, 64'h0, 1'b0}});
    directed_rows.push_back('{1'b1, KIND_U64, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1,
                              '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0}});
    directed_rows.push_back('{1'b1, KIND_U64, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                              '{64'h1, 64'h0, 1'b0}});
    directed_rows.push_back('{1'b1, KIND_U32, 64'hDEAD_BEEF_0000_0007, 64'h1234_5678_0000_0002,
                              '{64'h3, 64'h1, 1'b0}});
    directed_rows.push_back('{1'b1, KIND_U32, 64'h0000_0000_0000_0005, 64'h0000_0000_FFFF_FFFF,
                              '{64'h0, 64'h5, 1'b0}});
    directed_rows.push_back('{1'b1, KIND_U64, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                              '{64'h0, 64'h0, 1'b0}});
    directed_rows.push_back('{1'b1, KIND_S64, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1,
                              '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0}});
    directed_rows.push_back('{1'b0, KIND_S32, 64'h1234_5678_FFFF_FFF9, 64'h0000_0000_0000_0002,
                              UNTYPED});
    directed_rows.push_back('{1'b0, KIND_S32, 64'h0000_0000_0000_0007, 64'hFFFF_FFFF_FFFF_FFFE,
                              UNTYPED});
    directed_rows.push_back('{1'b0, KIND_S32, 64'h0000_0000_FFFF_FFF9, 64'h0000_0000_FFFF_FFFE,
                              UNTYPED});
    directed_rows.push_back('{1'b0, KIND_S64, 64'hFFFF_FFFF_FFFF_FFF9, 64'h2, UNTYPED});
    directed_rows.push_back('{1'b0, KIND_S64, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                              UNTYPED});
    directed_rows.push_back('{1'b0, KIND_U64, 64'h8000_0000_0000_0000, 64'h3, UNTYPED});
    directed_rows.push_back('{1'b0, KIND_S32, 64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000,
                              UNTYPED});
    directed_rows.push_back('{1'b0, KIND_S32, 64'hFFFF_FFFF_8000_0000, 64'hAAAA_AAAA_0000_0001,
                              UNTYPED});
    directed_rows.push_back('{1'b0, KIND_S64, 64'h8000_0000_0000_0000, 64'h1, UNTYPED});
    directed_rows.push_back('{1'b0, KIND_S32, 64'h5555_5555_8000_0000, 64'h0000_0000_0000_0002,
                              UNTYPED});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      offer_request(row.kind, row.dividend, row.divisor,
                    row.typed ? row.result : divide_predict(row.kind, row.dividend, row.divisor));
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = ((i / 64) % 4) == 2;
      if (i == HOLD_AT) hold_off_req = 1'b1;
      if (i == DRAIN_AT) begin
        div_req.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
      end
      kind     = KIND_W'($urandom_range(0, 3));
      dividend = rand_operand();
      if ($urandom_range(0, 15) == 0)
        divisor = kind[KIND_WIDE_BIT] ? 64'h0 : {$urandom, 32'h0};
      else
        divisor = rand_operand();
      offer_request(kind, dividend, divisor, divide_predict(kind, dividend, divisor));
    end
    div_req.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("int_divider_signed_unsigned_top: match");
    else
      $display("int_divider_signed_unsigned_top: mismatch");
    $finish;
  end

  // result side
  initial begin
    int stall;
    div_rsp.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        div_rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      div_rsp.ready <= 1'b1;
      do @(posedge clk); while (!div_rsp.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && div_rsp.valid && div_rsp.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with none expected, actual q=%h r=%h z=%b", $time,
                 div_rsp.quotient, div_rsp.remainder, div_rsp.divide_by_zero);
        mismatch_count++;
      end else begin
        head_result = expected_results.pop_front();
        compare_field("quotient", head_result.quotient, div_rsp.quotient);
        compare_field("remainder", head_result.remainder, div_rsp.remainder);
        compare_field("divide_by_zero", 64'(head_result.divide_by_zero),
                      64'(div_rsp.divide_by_zero));
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (div_req.valid && div_req.ready) || (div_rsp.valid && div_rsp.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("int_divider_signed_unsigned_top: mismatch");
    $finish;
  end

endmodule
